/* rtl/core/dq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, operation and status codes, request and result types, and
// ring index and word conversion helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  // memory access issued by the controller
  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    word_t wdata;
  } ram_req_t;

  // result handed to the output register
  typedef struct packed {
    logic                load;
    logic                from_ram;
    logic [STATUS_W-1:0] status;
    count_t              occupancy;
  } result_t;

  function automatic addr_t ring_inc(input addr_t a);
    addr_t r;
    if (a == addr_t'(DEPTH - 1)) r = '0;
    else                         r = a + addr_t'(1);
    return r;
  endfunction

  function automatic addr_t ring_dec(input addr_t a);
    addr_t r;
    if (a == '0) r = addr_t'(DEPTH - 1);
    else         r = a - addr_t'(1);
    return r;
  endfunction

  // (a + b) mod DEPTH for a, b below DEPTH
  function automatic addr_t ring_add(input addr_t a, input addr_t b);
    logic [ADDR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (ADDR_W + 1)'(DEPTH)) sum = sum - (ADDR_W + 1)'(DEPTH);
    return sum[ADDR_W-1:0];
  endfunction

  function automatic word_t to_word(input logic signed [VALUE_W-1:0] v);
    return word_t'(v);
  endfunction

  function automatic logic signed [VALUE_W-1:0] from_word(input word_t w);
    logic signed [DATA_WIDTH-1:0] s;
    s = signed'(w);
    return VALUE_W'(s);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/double_ended_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed values kept in a ring buffer RAM.
// ----------------------------------------------------------------------------
// Each input transaction carries an operation in s_axis_tuser (push front,
// push back, pop front, pop back) and a push value in s_axis_tdata, and gives
// exactly one output transaction with the popped value, a status (ok, empty
// on pop, full on push) and the entry count after the operation. Pushes and
// refused operations give their result directly; a successful pop waits in
// the read state for the registered entry RAM data; no new operation is
// taken. The output register lets the next operation be accepted in the same
// cycle the previous result is taken. Entries are read only after they were
// written, so the RAM needs no clearing after reset.
module double_ended_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] pop_value, [36:32] occupancy
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  dq_pkg::ram_req_t ram_req;
  dq_pkg::result_t  res;
  dq_pkg::word_t    rdata;

  logic                                 out_busy;
  logic signed [dq_pkg::VALUE_W-1:0]    out_pop_value;
  logic [dq_pkg::STATUS_W-1:0]          out_status;
  dq_pkg::count_t                       out_occupancy;

  assign out_busy = m_axis_tvalid && !m_axis_tready;

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .mode       (s_axis_tuser),
    .push_value (signed'(s_axis_tdata)),
    .out_busy   (out_busy),
    .ram_req    (ram_req),
    .res        (res)
  );

  dq_ram #(
    .DEPTH  (dq_pkg::DEPTH),
    .WIDTH  (dq_pkg::DATA_WIDTH),
    .ADDR_W (dq_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_pop_value <= res.from_ram ? dq_pkg::from_word(rdata) : '0;
      out_status    <= res.status;
      out_occupancy <= res.occupancy;
    end
  end

  assign m_axis_tdata = {(40 - dq_pkg::VALUE_W - dq_pkg::CNT_W)'(0),
                         out_occupancy, out_pop_value};
  assign m_axis_tuser = out_status;

  // read data is always consumed the cycle after a pop read
  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    ram_req.re |=> (res.load && res.from_ram))
    else $error("pop read not followed by result load");

  // no new operation while a pop read is in flight
  a_no_accept_during_read: assert property (@(posedge clk) disable iff (rst)
    ram_req.re |=> !s_axis_tready)
    else $error("input accepted during pop read");

  // refused pop reports an empty queue and a zero value
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_status == dq_pkg::ST_EMPTY)) |->
      ((out_occupancy == '0) && (out_pop_value == '0)))
    else $error("empty status with nonzero value or count");

  // refused push reports a full queue
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_status == dq_pkg::ST_FULL)) |->
      (out_occupancy == dq_pkg::count_t'(dq_pkg::DEPTH)))
    else $error("full status with count below depth");

endmodule
`default_nettype wire

/* rtl/core/dq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/dq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Front pointer and entry count, operation decode and memory sequencing.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [dq_pkg::MODE_W-1:0]            mode,
  input  wire logic signed [dq_pkg::VALUE_W-1:0]    push_value,
  input  wire logic                                 out_busy,
  output dq_pkg::ram_req_t                          ram_req,
  output dq_pkg::result_t                           res
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic           state, state_next;
  dq_pkg::addr_t  front, front_next;
  dq_pkg::count_t count, count_next;

  logic accept;
  logic full;
  logic empty;

  assign in_ready = (state == S_IDLE) && !out_busy;
  assign accept   = in_valid && in_ready;
  assign full     = (count == dq_pkg::count_t'(dq_pkg::DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    state_next    = state;
    front_next    = front;
    count_next    = count;
    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.addr  = front;
    ram_req.wdata = dq_pkg::to_word(push_value);
    res.load      = 1'b0;
    res.from_ram  = 1'b0;
    res.status    = dq_pkg::ST_OK;
    res.occupancy = count;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res.load = 1'b1;
          unique case (mode)
            dq_pkg::MODE_PUSH_FRONT: begin
              if (full) begin
                res.status = dq_pkg::ST_FULL;
              end else begin
                front_next   = dq_pkg::ring_dec(front);
                count_next   = count + dq_pkg::count_t'(1);
                ram_req.we   = 1'b1;
                ram_req.addr = dq_pkg::ring_dec(front);
              end
            end
            dq_pkg::MODE_PUSH_BACK: begin
              if (full) begin
                res.status = dq_pkg::ST_FULL;
              end else begin
                count_next   = count + dq_pkg::count_t'(1);
                ram_req.we   = 1'b1;
                ram_req.addr = dq_pkg::ring_add(front, dq_pkg::addr_t'(count));
              end
            end
            dq_pkg::MODE_POP_FRONT: begin
              if (empty) begin
                res.status = dq_pkg::ST_EMPTY;
              end else begin
                // result goes out once the read data is back
                res.load     = 1'b0;
                front_next   = dq_pkg::ring_inc(front);
                count_next   = count - dq_pkg::count_t'(1);
                ram_req.re   = 1'b1;
                ram_req.addr = front;
                state_next   = S_READ;
              end
            end
            dq_pkg::MODE_POP_BACK: begin
              if (empty) begin
                res.status = dq_pkg::ST_EMPTY;
              end else begin
                res.load     = 1'b0;
                count_next   = count - dq_pkg::count_t'(1);
                ram_req.re   = 1'b1;
                ram_req.addr = dq_pkg::ring_add(front,
                                 dq_pkg::addr_t'(count - dq_pkg::count_t'(1)));
                state_next   = S_READ;
              end
            end
            default: begin
              res.load = 1'b0;
            end
          endcase
          res.occupancy = count_next;
        end
      end
      S_READ: begin
        res.load     = 1'b1;
        res.from_ram = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the double-ended queue: pushes and pops at both ends,
// full and empty refusals, and the entry count. Results are checked against
// hand-written expectations or a behavioral copy of the deque kept in step
// with every accepted operation, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import dq_pkg::*;

  localparam int ITEMS      = 1300;
  localparam int QUIET_MAX  = 1000;
  localparam int HOLD_LEN   = 80;

  typedef struct packed {
    logic [31:0]         value;
    logic [STATUS_W-1:0] status;
    logic [4:0]          count;
  } outcome_t;

  typedef struct packed {
    logic [MODE_W-1:0] op;
    logic [31:0]       value;
    logic [4:0]        reps;
    logic              known;
    outcome_t          want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] push_value
  logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] pop_value, [36:32] occupancy
  logic [1:0]  m_axis_tuser;        // [1:0] status

  // behavioral copy of the deque
  logic [31:0] ring_copy [DEPTH];
  int          head_slot = 0;
  int          held = 0;

  outcome_t    pending_outcomes[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_taken = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;
  bit          hold_done = 1'b0;

  // rows with known set carry a hand-written expectation
  plan_row_t directed_plan [16] = '{
    '{MODE_POP_FRONT,  32'hFFFFFFFF, 5'd1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{MODE_POP_BACK,   32'hFFFFFFFF, 5'd1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{MODE_PUSH_FRONT, 32'h7FFFFFFF, 5'd1,  1'b1, '{32'h0, ST_OK, 5'd1}},
    '{MODE_PUSH_BACK,  32'h80000000, 5'd1,  1'b1, '{32'h0, ST_OK, 5'd2}},
    '{MODE_POP_FRONT,  32'h0,        5'd1,  1'b1, '{32'h7FFFFFFF, ST_OK, 5'd1}},
    '{MODE_POP_BACK,   32'h0,        5'd1,  1'b1, '{32'h80000000, ST_OK, 5'd0}},
    '{MODE_POP_BACK,   32'h0,        5'd1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{MODE_PUSH_FRONT, 32'h0,        5'd1,  1'b1, '{32'h0, ST_OK, 5'd1}},
    '{MODE_PUSH_BACK,  32'hFFFFFFFF, 5'd1,  1'b1, '{32'h0, ST_OK, 5'd2}},
    '{MODE_PUSH_FRONT, 32'h12345678, 5'd14, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'hDEADBEEF, 5'd1,  1'b1, '{32'h0, ST_FULL, 5'd16}},
    '{MODE_PUSH_FRONT, 32'h55555555, 5'd1,  1'b1, '{32'h0, ST_FULL, 5'd16}},
    '{MODE_POP_FRONT,  32'hAAAAAAAA, 5'd3,  1'b0, '0},
    '{MODE_PUSH_BACK,  32'h00000001, 5'd2,  1'b0, '0},
    '{MODE_POP_BACK,   32'h0,        5'd2,  1'b0, '0},
    '{MODE_POP_FRONT,  32'h0,        5'd1,  1'b0, '0}
  };

  double_ended_queue uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  task automatic deque_apply(input logic [MODE_W-1:0] op, input logic [31:0] v,
                             output outcome_t r);
    int slot;
    r = '0;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (held == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == MODE_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slot = head_slot;
          end else begin
            slot = (head_slot + held) % DEPTH;
          end
          ring_copy[slot] = v;
          held++;
          r.status = ST_OK;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else if (op == MODE_POP_FRONT) begin
          r.value = ring_copy[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          held--;
          r.status = ST_OK;
        end else begin
          r.value = ring_copy[(head_slot + held - 1) % DEPTH];
          held--;
          r.status = ST_OK;
        end
      end
    endcase
    r.count = held[4:0];
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("MISMATCH %s: expected %0h, got %0h at %0t ns", what, want, got, $time);
    mismatches++;
  endtask

  // drives one operation and records what it should produce once accepted
  task automatic offer(input logic [MODE_W-1:0] op, input logic [31:0] v,
                       input bit known, input outcome_t want);
    outcome_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    deque_apply(op, v, predicted);
    pending_outcomes.push_back(known ? want : predicted);
    items_sent++;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h00000000;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      3: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin : drive_ops
    int lean;
    int push_pct;
    bit paused;
    logic [MODE_W-1:0] op;
    lean = 2;
    paused = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);

    foreach (directed_plan[i]) begin
      for (int k = 0; k < directed_plan[i].reps; k++)
        offer(directed_plan[i].op, directed_plan[i].value + k,
              directed_plan[i].known, directed_plan[i].want);
    end

    for (int n = 0; items_sent < ITEMS; n++) begin
      if (n % 40 == 0) lean = $urandom_range(2);
      push_pct = (lean == 0) ? 80 : (lean == 1) ? 20 : 50;
      steady = (items_sent >= 600 && items_sent < 800);
      if (!paused && items_sent >= 400) begin
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge clk);
      end
      if ($urandom_range(99) < push_pct)
        op = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
      else
        op = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
      offer(op, pick_value(), 1'b0, '0);
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_taken >= 250) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_taken++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no operation pending", '0,
                        {m_axis_tuser, m_axis_tdata});
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tdata[31:0] !== want.value)
          report_mismatch("pop_value", want.value, m_axis_tdata[31:0]);
        if (m_axis_tuser !== want.status)
          report_mismatch("status", want.status, m_axis_tuser);
        if (m_axis_tdata[36:32] !== want.count)
          report_mismatch("occupancy", want.count, m_axis_tdata[36:32]);
        if (m_axis_tdata[39:37] !== 3'b000)
          report_mismatch("tdata padding", 3'b000, m_axis_tdata[39:37]);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
